[hw/rtl/kaf_pkg.sv]
package kaf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RegW  = 31;
  localparam int unsigned AccW  = 34;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_STOP   = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;

  localparam logic [3:0] REG_ANGLE_NOISE = 4'd0;
  localparam logic [3:0] REG_BIAS_NOISE  = 4'd1;
  localparam logic [3:0] REG_MEAS_NOISE  = 4'd2;
  localparam logic [3:0] REG_PERIOD      = 4'd3;
  localparam logic [3:0] REG_OBS_GAIN    = 4'd4;
  localparam logic [3:0] REG_INIT_AA     = 4'd5;
  localparam logic [3:0] REG_INIT_CROSS  = 4'd6;
  localparam logic [3:0] REG_INIT_BB     = 4'd7;

  localparam logic [RegW-1:0]  RST_ANGLE_NOISE = 31'd268435;
  localparam logic [RegW-1:0]  RST_BIAS_NOISE  = 31'd805306;
  localparam logic [RegW-1:0]  RST_MEAS_NOISE  = 31'd134217728;
  localparam logic [RegW-1:0]  RST_PERIOD      = 31'd1342177;
  localparam logic [DataW-1:0] RST_OBS_GAIN    = 32'd268435456;
  localparam logic [RegW-1:0]  RST_INIT_AA     = 31'd268435456;
  localparam logic [DataW-1:0] RST_INIT_CROSS  = 32'd0;
  localparam logic [RegW-1:0]  RST_INIT_BB     = 31'd268435456;

  typedef struct packed {
    logic use_prod;
    logic neg_prod;
  } mac_ctl_t;

endpackage

[hw/rtl/kalman_angle_fusion.sv]
// Two-state angle filter: fuses an accelerometer tilt angle with a gyro rate,
// tracking angle, gyro bias and a 2x2 covariance (Q16.16 angles, Q4.28 rest).
//
// Input channel (in_valid/in_ready): one transaction per command. Action
// sample runs the filter when started, stop clears the estimate and reloads
// the covariance from the init registers, start enables updates.
// Output channel (out_valid/out_ready): exactly one transaction per input,
// carrying angle, bias-corrected rate and the running flag.
//
// Non-running items: stop, start, idle samples and unused codes go from
// acceptance to the output state and are loaded into the output register
// once it is free; in_ready returns as that register loads. A running sample
// steps through the sequencer: 20 steps of the shared multiply-accumulate
// unit plus two gain steps (start, 60 bit-serial divider iterations,
// hand-off), then reaches the output state likewise. One item is in flight
// at a time; in_ready is high only while the sequencer is idle.
//
// Reset returns every configuration register to its default and acts as a
// stop. A stalled receiver holds the result in the output register; the
// next input is still taken and processed, then waits for that register.
// Configuration writes (cfg_we) must only happen while the block is idle.
module kalman_angle_fusion import kaf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_action,
  input  logic signed [DataW-1:0] in_accel_angle,
  input  logic signed [DataW-1:0] in_gyro_rate,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DataW-1:0] out_angle,
  output logic signed [DataW-1:0] out_angle_rate,
  output logic                    out_running,
  input  logic                    cfg_we,
  input  logic [3:0]              cfg_index,
  input  logic [DataW-1:0]        cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  // sequencer steps
  localparam logic [4:0] S_R    = 5'd0;
  localparam logic [4:0] S_ANG1 = 5'd1;
  localparam logic [4:0] S_D0   = 5'd2;
  localparam logic [4:0] S_DNEG = 5'd3;
  localparam logic [4:0] S_AA1  = 5'd4;
  localparam logic [4:0] S_AB1  = 5'd5;
  localparam logic [4:0] S_BA1  = 5'd6;
  localparam logic [4:0] S_BB1  = 5'd7;
  localparam logic [4:0] S_ERR  = 5'd8;
  localparam logic [4:0] S_P0   = 5'd9;
  localparam logic [4:0] S_P1   = 5'd10;
  localparam logic [4:0] S_E    = 5'd11;
  localparam logic [4:0] S_T1   = 5'd12;
  localparam logic [4:0] S_K0   = 5'd13;
  localparam logic [4:0] S_K1   = 5'd14;
  localparam logic [4:0] S_AA2  = 5'd15;
  localparam logic [4:0] S_AB2  = 5'd16;
  localparam logic [4:0] S_BA2  = 5'd17;
  localparam logic [4:0] S_BB2  = 5'd18;
  localparam logic [4:0] S_ANG2 = 5'd19;
  localparam logic [4:0] S_BIAS = 5'd20;
  localparam logic [4:0] S_RATE = 5'd21;

  function automatic logic signed [AccW-1:0] sx(input logic signed [DataW-1:0] v);
    sx = {{(AccW-DataW){v[DataW-1]}}, v};
  endfunction

  function automatic logic signed [AccW-1:0] nx(input logic signed [DataW-1:0] v);
    nx = -{{(AccW-DataW){v[DataW-1]}}, v};
  endfunction

  function automatic logic signed [AccW-1:0] ux(input logic [RegW-1:0] v);
    ux = {{(AccW-RegW){1'b0}}, v};
  endfunction

  // configuration registers
  logic [RegW-1:0]  qa_r, qb_r, rn_r, dt_r, init_aa_r, init_bb_r;
  logic [DataW-1:0] obs_r, init_x_r;

  // filter state
  logic signed [DataW-1:0] angle_r, bias_r, rate_r, aa_r, ab_r, ba_r, bb_r;
  logic                    run_r;

  // step temporaries and latched inputs
  logic signed [DataW-1:0] accel_r, gyro_r;
  logic signed [DataW-1:0] r_r, d0_r, dneg_r, err_r, p0_r, p1_r, e_r, t1_r, k0_r, k1_r;

  logic [1:0] state_r;
  logic [4:0] step_r;
  logic       phase_r;
  logic       out_valid_r;

  logic signed [DataW-1:0] mul_a, mul_b, mac_res, div_num, div_q;
  logic signed [AccW-1:0]  add_a, add_b, add_c;
  mac_ctl_t                mac_ctl;
  logic                    div_start, div_done;
  logic                    in_fire, step_wr, is_div;
  logic signed [DataW-1:0] dt_s, qb_s, c_s;

  assign in_ready  = state_r == ST_IDLE;
  assign in_fire   = in_valid && in_ready;
  assign dt_s      = signed'({1'b0, dt_r});
  assign qb_s      = signed'({1'b0, qb_r});
  assign c_s       = signed'(obs_r);
  assign is_div    = (step_r == S_K0) || (step_r == S_K1);
  assign div_start = (state_r == ST_RUN) && is_div && !phase_r;
  assign div_num   = (step_r == S_K0) ? p0_r : p1_r;
  assign step_wr   = (state_r == ST_RUN) && phase_r && (!is_div || div_done);

  // operand selection for the shared multiply-accumulate unit
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    add_a   = '0;
    add_b   = '0;
    add_c   = '0;
    mac_ctl = '{use_prod: 1'b1, neg_prod: 1'b0};
    case (step_r)
      S_R, S_RATE: begin
        add_a = sx(gyro_r); add_b = nx(bias_r); mac_ctl.use_prod = 1'b0;
      end
      S_ANG1: begin mul_a = r_r;    mul_b = dt_s; add_a = sx(angle_r); end
      S_D0: begin
        add_a = ux(qa_r); add_b = nx(ab_r); add_c = nx(ba_r); mac_ctl.use_prod = 1'b0;
      end
      S_DNEG: begin add_a = nx(bb_r); mac_ctl.use_prod = 1'b0; end
      S_AA1:  begin mul_a = d0_r;   mul_b = dt_s; add_a = sx(aa_r); end
      S_AB1:  begin mul_a = dneg_r; mul_b = dt_s; add_a = sx(ab_r); end
      S_BA1:  begin mul_a = dneg_r; mul_b = dt_s; add_a = sx(ba_r); end
      S_BB1:  begin mul_a = qb_s;   mul_b = dt_s; add_a = sx(bb_r); end
      S_ERR: begin
        add_a = sx(accel_r); add_b = nx(angle_r); mac_ctl.use_prod = 1'b0;
      end
      S_P0:   begin mul_a = c_s; mul_b = aa_r; end
      S_P1:   begin mul_a = c_s; mul_b = ba_r; end
      S_E:    begin mul_a = c_s; mul_b = p0_r; add_a = ux(rn_r); end
      S_T1:   begin mul_a = c_s; mul_b = ab_r; end
      S_AA2:  begin mul_a = k0_r; mul_b = p0_r; add_a = sx(aa_r); mac_ctl.neg_prod = 1'b1; end
      S_AB2:  begin mul_a = k0_r; mul_b = t1_r; add_a = sx(ab_r); mac_ctl.neg_prod = 1'b1; end
      S_BA2:  begin mul_a = k1_r; mul_b = p0_r; add_a = sx(ba_r); mac_ctl.neg_prod = 1'b1; end
      S_BB2:  begin mul_a = k1_r; mul_b = t1_r; add_a = sx(bb_r); mac_ctl.neg_prod = 1'b1; end
      S_ANG2: begin mul_a = k0_r; mul_b = err_r; add_a = sx(angle_r); end
      S_BIAS: begin mul_a = k1_r; mul_b = err_r; add_a = sx(bias_r); end
      default: begin
        mac_ctl.use_prod = 1'b0;
      end
    endcase
  end

  kaf_mac u_mac (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .add_a  (add_a),
    .add_b  (add_b),
    .add_c  (add_c),
    .ctl    (mac_ctl),
    .result (mac_res)
  );

  kaf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (e_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // configuration write port; ignore indexes past the last register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_r      <= RST_ANGLE_NOISE;
      qb_r      <= RST_BIAS_NOISE;
      rn_r      <= RST_MEAS_NOISE;
      dt_r      <= RST_PERIOD;
      obs_r     <= RST_OBS_GAIN;
      init_aa_r <= RST_INIT_AA;
      init_x_r  <= RST_INIT_CROSS;
      init_bb_r <= RST_INIT_BB;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ANGLE_NOISE: qa_r      <= cfg_data[RegW-1:0];
        REG_BIAS_NOISE:  qb_r      <= cfg_data[RegW-1:0];
        REG_MEAS_NOISE:  rn_r      <= cfg_data[RegW-1:0];
        REG_PERIOD:      dt_r      <= cfg_data[RegW-1:0];
        REG_OBS_GAIN:    obs_r     <= cfg_data;
        REG_INIT_AA:     init_aa_r <= cfg_data[RegW-1:0];
        REG_INIT_CROSS:  init_x_r  <= cfg_data;
        REG_INIT_BB:     init_bb_r <= cfg_data[RegW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= S_R;
      phase_r <= 1'b0;
      run_r   <= 1'b0;
      angle_r <= '0;
      bias_r  <= '0;
      rate_r  <= '0;
      aa_r    <= signed'({1'b0, RST_INIT_AA});
      ab_r    <= signed'(RST_INIT_CROSS);
      ba_r    <= signed'(RST_INIT_CROSS);
      bb_r    <= signed'({1'b0, RST_INIT_BB});
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            step_r  <= S_R;
            phase_r <= 1'b0;
            state_r <= ST_OUT;
            case (in_action)
              ACT_SAMPLE: begin
                if (run_r) state_r <= ST_RUN;
              end
              ACT_STOP: begin
                angle_r <= '0;
                bias_r  <= '0;
                rate_r  <= '0;
                aa_r    <= signed'({1'b0, init_aa_r});
                ab_r    <= signed'(init_x_r);
                ba_r    <= signed'(init_x_r);
                bb_r    <= signed'({1'b0, init_bb_r});
                run_r   <= 1'b0;
              end
              ACT_START: run_r <= 1'b1;
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else if (step_wr) begin
            phase_r <= 1'b0;
            step_r  <= step_r + 5'd1;
            if (step_r == S_RATE) state_r <= ST_OUT;
            case (step_r)
              S_ANG1, S_ANG2: angle_r <= mac_res;
              S_AA1, S_AA2:   aa_r    <= mac_res;
              S_AB1, S_AB2:   ab_r    <= mac_res;
              S_BA1, S_BA2:   ba_r    <= mac_res;
              S_BB1, S_BB2:   bb_r    <= mac_res;
              S_BIAS:         bias_r  <= mac_res;
              S_RATE:         rate_r  <= mac_res;
              default: ;
            endcase
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // temporaries of one sample, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      accel_r <= in_accel_angle;
      gyro_r  <= in_gyro_rate;
    end
    if (step_wr) begin
      case (step_r)
        S_R:    r_r    <= mac_res;
        S_D0:   d0_r   <= mac_res;
        S_DNEG: dneg_r <= mac_res;
        S_ERR:  err_r  <= mac_res;
        S_P0:   p0_r   <= mac_res;
        S_P1:   p1_r   <= mac_res;
        S_E:    e_r    <= mac_res;
        S_T1:   t1_r   <= mac_res;
        S_K0:   k0_r   <= div_q;
        S_K1:   k1_r   <= div_q;
        default: ;
      endcase
    end
  end

  // output register: load when the previous result has been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_valid_r    <= 1'b1;
      out_angle      <= angle_r;
      out_angle_rate <= rate_r;
      out_running    <= run_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_angle) && $stable(out_running))
    else $error("result dropped while stalled");

  a_div_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> state_r == ST_RUN && !phase_r)
    else $error("divider started outside a gain step");

  a_start_sets_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_action == ACT_START |=> run_r)
    else $error("start did not enable the filter");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_action == ACT_STOP |=> angle_r == '0 && rate_r == '0 && !run_r)
    else $error("stop did not clear the estimate");
`endif

endmodule

[hw/rtl/kaf_mac.sv]
module kaf_mac import kaf_pkg::*; (
  input  logic                    clk,
  input  logic signed [DataW-1:0] mul_a,
  input  logic signed [DataW-1:0] mul_b,
  input  logic signed [AccW-1:0]  add_a,
  input  logic signed [AccW-1:0]  add_b,
  input  logic signed [AccW-1:0]  add_c,
  input  mac_ctl_t                ctl,
  output logic signed [DataW-1:0] result
);

  logic signed [63:0] prod_r;
  logic signed [63:0] rnd;
  logic signed [35:0] m;
  logic signed [37:0] term;
  logic signed [37:0] sum;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // round half up, then floor by taking the upper bits
  assign rnd = prod_r + 64'sd134217728;
  assign m   = rnd[63:28];

  always_comb begin
    if (!ctl.use_prod) begin
      term = {{4{add_c[AccW-1]}}, add_c};
    end else if (ctl.neg_prod) begin
      term = -{{2{m[35]}}, m};
    end else begin
      term = {{2{m[35]}}, m};
    end
    sum = {{4{add_a[AccW-1]}}, add_a} + {{4{add_b[AccW-1]}}, add_b} + term;
    if (sum > 38'sh0_7FFF_FFFF) begin
      result = 32'sh7FFF_FFFF;
    end else if (sum < -38'sh0_8000_0000) begin
      result = -32'sh8000_0000;
    end else begin
      result = sum[31:0];
    end
  end

endmodule

[hw/rtl/kaf_div.sv]
module kaf_div import kaf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DataW-1:0] num,
  input  logic signed [DataW-1:0] den,
  output logic                    done,
  output logic signed [DataW-1:0] quo
);

  localparam int unsigned QW = DataW + 28;

  logic          busy_r;
  logic          done_r;
  logic [5:0]    cnt_r;
  logic          neg_r;
  logic          zero_r;
  logic [QW-1:0] dvd_r;
  logic [31:0]   dsr_r;
  logic [31:0]   rem_r;
  logic [32:0]   rem_sh;
  logic          fit;
  logic signed [DataW-1:0] quo_r;
  logic [31:0]   num_mag;
  logic [31:0]   den_mag;
  logic [QW-1:0] q_fin;

  assign num_mag = num[31] ? 32'(-num) : 32'(num);
  assign den_mag = den[31] ? 32'(-den) : 32'(den);
  assign rem_sh  = {rem_r, dvd_r[QW-1]};
  assign fit     = rem_sh >= {1'b0, dsr_r};
  assign q_fin   = {dvd_r[QW-2:0], fit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= num[31] ^ den[31];
      zero_r <= den == '0;
      dvd_r  <= {num_mag, 28'd0};
      dsr_r  <= den_mag;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r <= fit ? 32'(rem_sh - {1'b0, dsr_r}) : rem_sh[31:0];
      dvd_r <= q_fin;
      if (cnt_r == 6'(QW - 1)) begin
        if (zero_r) begin
          quo_r <= '0;
        end else if (!neg_r) begin
          quo_r <= (q_fin > QW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : signed'(q_fin[31:0]);
        end else begin
          quo_r <= (q_fin >= QW'(33'h1_0000_0000 >> 1)) ? -32'sh8000_0000
                                                        : -signed'(q_fin[31:0]);
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[dv/tb_kalman_angle_fusion.sv]
// Scoreboard: tracks the filter state, predicts one result per accepted
// transaction and checks the results that come back in order.
typedef struct {
  logic signed [31:0] angle;
  logic signed [31:0] angle_rate;
  logic               running;
} fusion_result_t;

class fusion_scoreboard;
  longint         cfg_reg[8];
  longint         est_angle, est_bias, est_rate;
  longint         p_aa, p_ab, p_ba, p_bb;
  bit             run_en;
  fusion_result_t pending[$];
  int             mismatches;

  function new();
    cfg_reg[kaf_pkg::REG_ANGLE_NOISE] = kaf_pkg::RST_ANGLE_NOISE;
    cfg_reg[kaf_pkg::REG_BIAS_NOISE]  = kaf_pkg::RST_BIAS_NOISE;
    cfg_reg[kaf_pkg::REG_MEAS_NOISE]  = kaf_pkg::RST_MEAS_NOISE;
    cfg_reg[kaf_pkg::REG_PERIOD]      = kaf_pkg::RST_PERIOD;
    cfg_reg[kaf_pkg::REG_OBS_GAIN]    = longint'(signed'(kaf_pkg::RST_OBS_GAIN));
    cfg_reg[kaf_pkg::REG_INIT_AA]     = kaf_pkg::RST_INIT_AA;
    cfg_reg[kaf_pkg::REG_INIT_CROSS]  = longint'(signed'(kaf_pkg::RST_INIT_CROSS));
    cfg_reg[kaf_pkg::REG_INIT_BB]     = kaf_pkg::RST_INIT_BB;
    mismatches = 0;
    reinit();
  endfunction

  function void reinit();
    est_angle = 0;
    est_bias  = 0;
    est_rate  = 0;
    p_aa   = cfg_reg[kaf_pkg::REG_INIT_AA];
    p_ab   = cfg_reg[kaf_pkg::REG_INIT_CROSS];
    p_ba   = cfg_reg[kaf_pkg::REG_INIT_CROSS];
    p_bb   = cfg_reg[kaf_pkg::REG_INIT_BB];
    run_en = 1'b0;
  endfunction

  function void write_reg(logic [3:0] idx, logic [31:0] data);
    if (idx == kaf_pkg::REG_OBS_GAIN || idx == kaf_pkg::REG_INIT_CROSS)
      cfg_reg[idx] = longint'(signed'(data));
    else if (idx <= kaf_pkg::REG_INIT_BB)
      cfg_reg[idx] = longint'({1'b0, data[30:0]});
  endfunction

  function longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q4.28 product, rounded half up (floor after adding half an LSB).
  function longint qmul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< 27);
    return p >>> 28;
  endfunction

  function longint qgain(longint num, longint den);
    if (den == 0) return 0;
    return clip32((num * 64'sd268435456) / den);
  endfunction

  function void run_sample(longint accel, longint gyro);
    longint qa, qb, rn, dt, c;
    longint r, d0, dneg, err, p0, p1, e, k0, k1, t1;
    qa = cfg_reg[kaf_pkg::REG_ANGLE_NOISE];
    qb = cfg_reg[kaf_pkg::REG_BIAS_NOISE];
    rn = cfg_reg[kaf_pkg::REG_MEAS_NOISE];
    dt = cfg_reg[kaf_pkg::REG_PERIOD];
    c  = cfg_reg[kaf_pkg::REG_OBS_GAIN];
    // predict
    r = clip32(gyro - est_bias);
    est_angle = clip32(est_angle + qmul(r, dt));
    d0   = clip32(qa - p_ab - p_ba);
    dneg = clip32(-p_bb);
    p_aa = clip32(p_aa + qmul(d0, dt));
    p_ab = clip32(p_ab + qmul(dneg, dt));
    p_ba = clip32(p_ba + qmul(dneg, dt));
    p_bb = clip32(p_bb + qmul(qb, dt));
    // update
    err = clip32(accel - est_angle);
    p0  = clip32(qmul(c, p_aa));
    p1  = clip32(qmul(c, p_ba));
    e   = clip32(rn + qmul(c, p0));
    k0  = qgain(p0, e);
    k1  = qgain(p1, e);
    t1  = clip32(qmul(c, p_ab));
    p_aa = clip32(p_aa - qmul(k0, p0));
    p_ab = clip32(p_ab - qmul(k0, t1));
    p_ba = clip32(p_ba - qmul(k1, p0));
    p_bb = clip32(p_bb - qmul(k1, t1));
    est_angle = clip32(est_angle + qmul(k0, err));
    est_bias  = clip32(est_bias + qmul(k1, err));
    est_rate  = clip32(gyro - est_bias);
  endfunction

  function void note_input(logic [1:0] act, logic signed [31:0] accel,
                           logic signed [31:0] gyro);
    fusion_result_t res;
    case (act)
      kaf_pkg::ACT_SAMPLE: if (run_en) run_sample(accel, gyro);
      kaf_pkg::ACT_STOP:   reinit();
      kaf_pkg::ACT_START:  run_en = 1'b1;
      default: ;
    endcase
    res.angle      = est_angle[31:0];
    res.angle_rate = est_rate[31:0];
    res.running    = run_en;
    pending.push_back(res);
  endfunction

  function void check_result(logic signed [31:0] angle, logic signed [31:0] rate,
                             logic running);
    fusion_result_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected result angle=%0d rate=%0d running=%0b",
                 angle, rate, running);
      return;
    end
    want = pending.pop_front();
    if (angle !== want.angle || rate !== want.angle_rate || running !== want.running) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"ERROR: result mismatch exp angle=%0d rate=%0d running=%0b, ",
                  "got angle=%0d rate=%0d running=%0b"},
                 want.angle, want.angle_rate, want.running, angle, rate, running);
    end
  endfunction
endclass

module tb_kalman_angle_fusion;
  import kaf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // A running sample is the slowest item and gaps and stalls are bounded by
  // pick_gap, so this leaves a wide margin over the 1982 items of the run.
  localparam longint CycleLimit = 3000000;
  localparam int     DrainWait  = 200;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              in_action;
  logic signed [DataW-1:0] in_accel_angle;
  logic signed [DataW-1:0] in_gyro_rate;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [DataW-1:0] out_angle;
  logic signed [DataW-1:0] out_angle_rate;
  logic                    out_running;
  logic                    cfg_we;
  logic [3:0]              cfg_index;
  logic [DataW-1:0]        cfg_data;

  fusion_scoreboard fusion_sb;
  longint           cycle_count;
  bit               no_idle;   // phases with back-to-back traffic on both sides

  kalman_angle_fusion u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_accel_angle (in_accel_angle),
    .in_gyro_rate   (in_gyro_rate),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_angle      (out_angle),
    .out_angle_rate (out_angle_rate),
    .out_running    (out_running),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: abort if the run hangs.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("tb_kalman_angle_fusion: done, errors");
        $finish;
      end
    end
  end

  // Mostly short gaps, a few long ones; none at all in no-idle phases.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: sample the handshake on pre-edge values, then pick the
  // next out_ready. Hold ready low for a random stretch to stall.
  initial begin
    int stall;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        fusion_sb.check_result(out_angle, out_angle_rate, out_running);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        stall = pick_gap();
        out_ready <= (stall == 0);
      end
    end
  end

  // Drive one transaction; hold valid and payload until accepted.
  task automatic send_item(logic [1:0] act, logic signed [31:0] accel,
                           logic signed [31:0] gyro);
    int gap;
    in_valid       <= 1'b1;
    in_action      <= act;
    in_accel_angle <= accel;
    in_gyro_rate   <= gyro;
    do @(posedge clk); while (!in_ready);
    fusion_sb.note_input(act, accel, gyro);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected result is back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (fusion_sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leave the enable high; the caller drops it after the last write.
  task automatic write_reg(logic [3:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    fusion_sb.write_reg(idx, data);
  endtask

  // Register values by flavor: 0 plausible, 1 maximum, 2 zero, 3 minimum
  // signed, 4 anything.
  function automatic logic [31:0] reg_value(logic [3:0] idx, int flavor);
    logic [31:0] top;
    bit          is_signed;
    top = {1'($urandom_range(0, 1)), 31'd0};   // toggle the unused top bit
    is_signed = (idx == REG_OBS_GAIN || idx == REG_INIT_CROSS);
    case (flavor)
      1: return is_signed ? 32'h7FFF_FFFF : (32'h7FFF_FFFF | top);
      2: return top & {32{!is_signed}};
      3: return is_signed ? 32'h8000_0000 : top;
      4: return $urandom;
      default: begin
        case (idx)
          REG_ANGLE_NOISE: return $urandom_range(0, 1 << 20);
          REG_BIAS_NOISE:  return $urandom_range(0, 1 << 22);
          REG_MEAS_NOISE:  return $urandom_range(1 << 24, 1 << 28);
          REG_PERIOD:      return $urandom_range(1 << 18, 1 << 24);
          REG_OBS_GAIN: begin
            if ($urandom_range(0, 3) == 0) return -$urandom_range(1 << 26, 1 << 29);
            return $urandom_range(1 << 26, 1 << 29);
          end
          REG_INIT_CROSS:  return $urandom_range(0, 1 << 26) - (1 << 25);
          default:         return $urandom_range(0, 1 << 29);
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 180 << 16) - (90 << 16);
    if (r < 85) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic run_random(int count);
    int          r;
    logic [1:0]  act;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 87)      act = ACT_SAMPLE;
      else if (r < 93) act = ACT_START;
      else if (r < 97) act = ACT_STOP;
      else             act = 2'd3;   // unused code, no operation
      send_item(act, pick_angle(), pick_angle());
    end
  endtask

  initial begin
    int flavor;
    fusion_sb      = new();
    no_idle        = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_SAMPLE;
    in_accel_angle = '0;
    in_gyro_rate   = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: samples while stopped, double start, field extremes,
    // unused code, stop mid-run.
    send_item(ACT_SAMPLE, 32'sd1000, 32'sd2000);
    send_item(ACT_START,  32'sd0, 32'sd0);
    send_item(ACT_START,  32'sd0, 32'sd0);
    send_item(ACT_SAMPLE, 32'sd65536, 32'sd0);
    send_item(ACT_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(ACT_SAMPLE, 32'h8000_0000, 32'h8000_0000);
    send_item(ACT_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(ACT_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(ACT_SAMPLE, 32'hFFFF_FFFF, 32'sd0);
    send_item(2'd3,       32'sd5, 32'sd5);
    send_item(ACT_STOP,   32'sd0, 32'sd0);
    send_item(ACT_SAMPLE, 32'sd7000, 32'sd7000);
    send_item(ACT_START,  32'sd0, 32'sd0);
    send_item(ACT_SAMPLE, 32'sd0, 32'sd0);
    run_random(450);

    // Phases: rewrite every register, then reinit and run. Flavors cover
    // maximum, zero (zero divisor), minimum gain, plausible and random settings.
    for (int ph = 0; ph < 9; ph++) begin
      wait_idle();
      no_idle = (ph % 3 == 2);
      flavor  = (ph < 5) ? ph : ((ph % 2) ? 0 : 4);
      for (int i = 0; i < 8; i++) write_reg(4'(i), reg_value(4'(i), flavor));
      write_reg(4'($urandom_range(8, 15)), $urandom);   // out of range, ignored
      cfg_we <= 1'b0;
      send_item(ACT_STOP,  32'sd0, 32'sd0);
      send_item(ACT_START, 32'sd0, 32'sd0);
      run_random((flavor == 0) ? 260 : 120);
    end

    // Drain, then allow the block to settle before judging.
    in_valid <= 1'b0;
    while (fusion_sb.pending.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (fusion_sb.mismatches == 0 && fusion_sb.pending.size() == 0) begin
      $display("tb_kalman_angle_fusion: done, clean");
    end else begin
      $display("tb_kalman_angle_fusion: done, errors");
    end
    $finish;
  end

endmodule

[kalman_angle_fusion.f]
hw/rtl/kaf_pkg.sv
hw/rtl/kaf_mac.sv
hw/rtl/kaf_div.sv
hw/rtl/kalman_angle_fusion.sv
dv/tb_kalman_angle_fusion.sv
